>>> hw/rtl/whfc_pkg.sv
// Shared types and constants for the WLAN frame header classifier.
// Holds the byte and record payload structs and the protocol constants.
// No dependencies.
package whfc_pkg;

	// One frame byte with its side information
	typedef struct packed {
		logic        is_data_frame;
		logic [7:0]  data_byte;
		logic        is_last;
		logic [11:0] sig_length;
		logic [47:0] arrival_time;
	} in_item_t;

	// One classified frame record
	typedef struct packed {
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] protocol_code;
		logic [11:0] out_length;
		logic [47:0] capture_time;
	} out_item_t;

	// Per-frame verdict handed from the parser to the output register
	typedef struct packed {
		logic      keep;
		out_item_t rec;
	} verdict_t;

	// Capture modes (code 3 behaves like MODE_ALL)
	localparam logic [1:0] MODE_ALL     = 2'd0;
	localparam logic [1:0] MODE_TCP_SYN = 2'd1;
	localparam logic [1:0] MODE_ARP     = 2'd2;

	// Register select, taken from address bit 3
	localparam logic REG_AP_MAC       = 1'b0;
	localparam logic REG_CAPTURE_MODE = 1'b1;

	// Header lengths including LLC/SNAP
	localparam logic [5:0] BASE_HDR_LEN = 6'd32;
	localparam logic [5:0] QOS_HDR_LEN  = 6'd34;

	localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
	localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ARP_CODE_BASE = 16'd900;
	localparam logic [3:0]  IPV4_VERSION  = 4'd4;
	localparam logic [7:0]  IP_PROTO_TCP  = 8'd6;
	localparam logic [7:0]  TCP_FLAG_SYN  = 8'h02;

endpackage

>>> hw/rtl/whfc_parse.sv
// Per-frame header parser: byte position, address match flags, captured fields
// and the keep/drop verdict on the last byte of a frame.
// Depends on whfc_pkg.
module whfc_parse #(
	parameter int MAX_FRAME_BYTES = 4095
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  whfc_pkg::in_item_t  item,
	input  logic [47:0]         ap_mac,
	input  logic [1:0]          capture_mode,
	output whfc_pkg::verdict_t  verdict
);
	import whfc_pkg::*;

	localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 1);

	// Address fields span bytes 4..21, six bytes each
	localparam logic [IDX_W-1:0] MAC_FIRST = IDX_W'(4);
	localparam logic [IDX_W-1:0] MAC_END   = IDX_W'(22);
	localparam logic [IDX_W-1:0] IDX_MAX   = IDX_W'(MAX_FRAME_BYTES);

	// Offsets past the header
	localparam logic [IDX_W-1:0] ARP_OP_OFF  = IDX_W'(6);
	localparam logic [IDX_W-1:0] ARP_SPA_OFF = IDX_W'(14);
	localparam logic [IDX_W-1:0] ARP_SPA_END = IDX_W'(18);
	localparam logic [IDX_W-1:0] ARP_TPA_OFF = IDX_W'(24);
	localparam logic [IDX_W-1:0] ARP_TPA_END = IDX_W'(28);
	localparam logic [IDX_W-1:0] IP_PROTO_OFF = IDX_W'(9);
	localparam logic [IDX_W-1:0] IP_SRC_OFF  = IDX_W'(12);
	localparam logic [IDX_W-1:0] IP_DST_OFF  = IDX_W'(16);
	localparam logic [IDX_W-1:0] IP_DST_END  = IDX_W'(20);
	localparam logic [IDX_W-1:0] TCP_FLAGS_OFF = IDX_W'(33);

	// Last index needed (bytes needed minus one)
	localparam logic [IDX_W-1:0] ARP_LAST_IDX = IDX_W'(27);
	localparam logic [IDX_W-1:0] IP_LAST_IDX  = IDX_W'(19);
	localparam logic [IDX_W-1:0] TCP_LAST_IDX = IDX_W'(33);
	localparam logic [11:0]      TCP_LEN_MIN  = 12'd34;

	typedef struct packed {
		logic [1:0] addr;
		logic [2:0] octet;
	} mac_slot_t;

	function automatic mac_slot_t mac_slot(input logic [4:0] rel);
		mac_slot_t s;
		if (rel >= 5'd12) begin
			s.addr  = 2'd2;
			s.octet = 3'(rel - 5'd12);
		end else if (rel >= 5'd6) begin
			s.addr  = 2'd1;
			s.octet = 3'(rel - 5'd6);
		end else begin
			s.addr  = 2'd0;
			s.octet = 3'(rel);
		end
		return s;
	endfunction

	logic [IDX_W-1:0] idx_q, idx_d;
	logic [2:0]       match_q, match_n, match_d;
	logic             qos_q, qos_n, qos_d;
	logic [15:0]      type_q, type_n, type_d;
	logic [15:0]      arp_op_q, arp_op_n, arp_op_d;
	logic [3:0]       ver_q, ver_n, ver_d;
	logic [7:0]       proto_q, proto_n, proto_d;
	logic [7:0]       tcp_q, tcp_n, tcp_d;
	logic [31:0]      sender_q, sender_n, sender_d;
	logic [31:0]      target_q, target_n, target_d;

	logic [5:0]       hdr;
	logic [IDX_W-1:0] hdr_w, off;
	logic             past_hdr, is_arp;
	mac_slot_t        slot;
	logic [7:0]       mac_byte;
	logic             base_ok, ip_ok, tcp_ok;

	always_comb begin
		qos_n    = (idx_q == '0) ? item.data_byte[7] : qos_q;
		hdr      = qos_n ? QOS_HDR_LEN : BASE_HDR_LEN;
		hdr_w    = IDX_W'(hdr);
		match_n  = match_q;
		type_n   = type_q;
		arp_op_n = arp_op_q;
		ver_n    = ver_q;
		proto_n  = proto_q;
		tcp_n    = tcp_q;
		sender_n = sender_q;
		target_n = target_q;

		// Address filter: clear the flag of an address on any byte mismatch
		slot = mac_slot(5'(idx_q[4:0] - 5'd4));
		case (slot.octet)
			3'd0:    mac_byte = ap_mac[47:40];
			3'd1:    mac_byte = ap_mac[39:32];
			3'd2:    mac_byte = ap_mac[31:24];
			3'd3:    mac_byte = ap_mac[23:16];
			3'd4:    mac_byte = ap_mac[15:8];
			default: mac_byte = ap_mac[7:0];
		endcase
		if (idx_q >= MAC_FIRST && idx_q < MAC_END && item.data_byte != mac_byte)
			match_n[slot.addr] = 1'b0;

		if (idx_q == hdr_w - IDX_W'(2) || idx_q == hdr_w - IDX_W'(1))
			type_n = {type_q[7:0], item.data_byte};

		is_arp   = (type_n == ETH_TYPE_ARP);
		past_hdr = (idx_q >= hdr_w);
		off      = idx_q - hdr_w;
		if (past_hdr) begin
			if (is_arp) begin
				if (off == ARP_OP_OFF || off == ARP_OP_OFF + IDX_W'(1))
					arp_op_n = {arp_op_q[7:0], item.data_byte};
				else if (off >= ARP_SPA_OFF && off < ARP_SPA_END)
					sender_n = {sender_q[23:0], item.data_byte};
				else if (off >= ARP_TPA_OFF && off < ARP_TPA_END)
					target_n = {target_q[23:0], item.data_byte};
			end else begin
				if (off == '0)
					ver_n = item.data_byte[7:4];
				else if (off == IP_PROTO_OFF)
					proto_n = item.data_byte;
				else if (off >= IP_SRC_OFF && off < IP_DST_OFF)
					sender_n = {sender_q[23:0], item.data_byte};
				else if (off >= IP_DST_OFF && off < IP_DST_END)
					target_n = {target_q[23:0], item.data_byte};
				else if (off == TCP_FLAGS_OFF)
					tcp_n = item.data_byte;
			end
		end

		// Verdict, valid only when the byte is the last of its frame
		base_ok = item.is_data_frame && (match_n != 3'b000) &&
			(item.sig_length > 12'(hdr)) && (idx_q >= hdr_w - IDX_W'(1));
		ip_ok   = (capture_mode != MODE_ARP) && (type_n == ETH_TYPE_IPV4) &&
			(idx_q >= hdr_w + IP_LAST_IDX) && (ver_n == IPV4_VERSION);
		tcp_ok  = (proto_n == IP_PROTO_TCP) &&
			(item.sig_length > 12'(hdr) + TCP_LEN_MIN) &&
			(idx_q >= hdr_w + TCP_LAST_IDX) && ((tcp_n & TCP_FLAG_SYN) != 8'd0);

		verdict.keep = 1'b0;
		verdict.rec.src_ip        = sender_n;
		verdict.rec.dst_ip        = target_n;
		verdict.rec.protocol_code = {8'd0, proto_n};
		verdict.rec.out_length    = item.sig_length;
		verdict.rec.capture_time  = item.arrival_time;
		if (base_ok) begin
			if (is_arp && capture_mode != MODE_TCP_SYN) begin
				verdict.keep = (idx_q >= hdr_w + ARP_LAST_IDX);
				verdict.rec.protocol_code = ARP_CODE_BASE + arp_op_n;
			end else if (ip_ok) begin
				verdict.keep = (capture_mode != MODE_TCP_SYN) || tcp_ok;
			end
		end

		// Advance the position, or clear the frame state after the last byte
		if (item.is_last) begin
			idx_d    = '0;
			match_d  = 3'b111;
			qos_d    = 1'b0;
			type_d   = '0;
			arp_op_d = '0;
			ver_d    = '0;
			proto_d  = '0;
			tcp_d    = '0;
			sender_d = '0;
			target_d = '0;
		end else begin
			idx_d    = (idx_q < IDX_MAX) ? idx_q + IDX_W'(1) : idx_q;
			match_d  = match_n;
			qos_d    = qos_n;
			type_d   = type_n;
			arp_op_d = arp_op_n;
			ver_d    = ver_n;
			proto_d  = proto_n;
			tcp_d    = tcp_n;
			sender_d = sender_n;
			target_d = target_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			match_q  <= 3'b111;
			qos_q    <= 1'b0;
			type_q   <= '0;
			arp_op_q <= '0;
			ver_q    <= '0;
			proto_q  <= '0;
			tcp_q    <= '0;
			sender_q <= '0;
			target_q <= '0;
		end else if (en) begin
			idx_q    <= idx_d;
			match_q  <= match_d;
			qos_q    <= qos_d;
			type_q   <= type_d;
			arp_op_q <= arp_op_d;
			ver_q    <= ver_d;
			proto_q  <= proto_d;
			tcp_q    <= tcp_d;
			sender_q <= sender_d;
			target_q <= target_d;
		end
	end

endmodule

>>> hw/rtl/wlan_frame_header_classifier_unit.sv
// Top level of the WLAN frame header classifier: APB register block, input
// stage register, header parser and record output register.
// Depends on whfc_pkg and whfc_parse.
//
// Usage:
// - Byte channel (byte_valid/byte_ready/byte_data): one frame byte per
//   transaction, byte 0 first, is_last set on the final byte. sig_length,
//   is_data_frame and arrival_time are taken from the last byte.
// - Record channel (rec_valid/rec_ready/rec_data): at most one record per
//   frame, produced from its last byte; frames that fail the filters give none.
// - APB port: ap_mac at byte address 0, capture_mode at byte address 8, 64-bit
//   data, pready tied high; address bits below bit 3 are ignored.
// Timing: one byte per cycle sustained unless a last byte stalls (see Stalls).
//   A byte is held in the stage register and parsed there; its record is then
//   registered in the output register for rec_data. The per-frame state
//   update (address compare, field capture) is the single stage of work.
// Stalls: while a record waits in the output register, non-last bytes keep
//   flowing; only a last byte holds in the stage register until the record
//   is taken (rec_ready), so no record is ever overwritten.
// Reset: arst_n clears the registers (ap_mac 0, mode 0), the frame state
//   and both valid flags; byte_ready is high from reset on.
module wlan_frame_header_classifier_unit #(
	parameter int MAX_FRAME_BYTES = 4095
) (
	input  logic                clk,
	input  logic                arst_n,
	// APB configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready,
	// Frame bytes
	input  logic                byte_valid,
	output logic                byte_ready,
	input  whfc_pkg::in_item_t  byte_data,
	// Records
	output logic                rec_valid,
	input  logic                rec_ready,
	output whfc_pkg::out_item_t rec_data
);
	import whfc_pkg::*;

	logic [47:0] ap_mac_q;
	logic [1:0]  capture_mode_q;
	logic        cfg_wr;

	in_item_t    item_s1;
	logic        valid_s1;
	logic        adv_s1;
	verdict_t    verdict;

	out_item_t   rec_q;
	logic        rec_valid_q;

	// Configuration registers: write in the APB access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ap_mac_q       <= '0;
			capture_mode_q <= MODE_ALL;
		end else if (cfg_wr) begin
			unique case (paddr[3])
				REG_AP_MAC:       ap_mac_q       <= pwdata[47:0];
				REG_CAPTURE_MODE: capture_mode_q <= pwdata[1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			REG_AP_MAC:       prdata = {16'd0, ap_mac_q};
			REG_CAPTURE_MODE: prdata = {62'd0, capture_mode_q};
			default:          prdata = '0;
		endcase
	end

	// Stage register: a non-last byte always advances; a last byte advances
	// only when the output register is free or being drained this cycle
	assign adv_s1     = valid_s1 && (!item_s1.is_last || !rec_valid_q || rec_ready);
	assign byte_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (byte_ready)
			valid_s1 <= byte_valid;
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid)
			item_s1 <= byte_data;
	end

	whfc_parse #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (adv_s1),
		.item         (item_s1),
		.ap_mac       (ap_mac_q),
		.capture_mode (capture_mode_q),
		.verdict      (verdict)
	);

	// Output register: load a kept record, drop valid once it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rec_valid_q <= 1'b0;
		else if (adv_s1 && item_s1.is_last && verdict.keep)
			rec_valid_q <= 1'b1;
		else if (rec_ready)
			rec_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_s1.is_last && verdict.keep)
			rec_q <= verdict.rec;
	end

	assign rec_valid = rec_valid_q;
	assign rec_data  = rec_q;

	// An empty stage register must always take a byte
	a_empty_stage_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> byte_ready)
		else $error("stage register empty but byte_ready low");

	// A record appears only from a last byte that advanced
	a_rec_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rec_valid) |-> $past(adv_s1 && item_s1.is_last))
		else $error("record produced without a last byte");

	// A waiting record is never replaced by the next frame's record
	a_rec_not_overwritten: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_valid && !rec_ready) |-> !(adv_s1 && item_s1.is_last))
		else $error("last byte advanced over a waiting record");

	// Kept frames are always longer than the shortest header
	a_rec_len: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid |-> (rec_data.out_length > 12'(BASE_HDR_LEN)))
		else $error("record with length not above header length");

endmodule
